// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BSEC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BSEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bsec_pkg.sv =====
// Shared types and constants of the binned segment event counter.
package bsec_pkg;

   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int unsigned MS_PER_SECOND   = 1000;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SEG   = 3'd1;
   localparam logic [2:0] ST_TIME_DAY = 3'd2;
   localparam logic [2:0] ST_SET_FULL = 3'd3;
   localparam logic [2:0] ST_BIN_OOR  = 3'd4;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_COUNT = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_COUNT,
      KIND_READ,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seg_id;
      logic [26:0] entry_time_ms;
      logic [2:0]  mode;
      logic [6:0]  read_bin;
      logic        read_bin_ok;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qout_type;

endpackage

// ===== rtl/core/binned_segment_event_counter_top.sv =====
// Top level of the binned segment event counter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, seg_id, entry_time_ms, mode_code, read_bin
//   rsp      out        rsp_valid/rsp_stall  status, bin_index, count_value
//   csr      in         APB psel/penable     interval_seconds @0, start_time_ms @4
//
// A request leaves the queue in S_IDLE; each monitored slot scanned takes a set-memory read
// and a compare (S_RD, S_CMP), a new ID is stored in S_CMP, and S_RES loads the result.
// A count adds a reciprocal multiply (S_SEC), a day check, 29 divider steps and a bin check;
// a count or read then adds indexing (S_IDX1, S_IDX2) and count-memory read-modify-write.
// After reset the MAX_BINS*SEGMENT_SLOTS*MODE_CODES count-memory words are cleared,
// one word a cycle; requests are stalled meanwhile.
// A two-deep queue holds requests while the back end works or rsp is stalled.
module binned_segment_event_counter_top import bsec_pkg::*; #(
   parameter int SEGMENT_SLOTS = 64,
   parameter int MODE_CODES    = 8,
   parameter int MAX_BINS      = 96
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_seg_id,
   input  logic [26:0] req_entry_time_ms,
   input  logic [2:0]  req_mode_code,
   input  logic [6:0]  req_read_bin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_bin_index,
   output logic [31:0] rsp_count_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "assert_macros.svh"

   logic [16:0] interval_ff;
   logic [26:0] start_ff;
   cmd_type     cmd;
   qout_type    head;
   logic        q_full;
   logic        pop;
   logic        clearing;
   logic        push;
   logic        csr_wr;

   // Hold requests off while the count memory is cleared or the queue is full.
   assign req_stall  = q_full || clearing;
   assign push       = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register 1 sits at byte address 4; the low address bits are ignored.
   always_comb begin
      csr_prdata = csr_paddr[2] ? {5'b0, start_ff} : {15'b0, interval_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 17'd900;
         start_ff    <= 27'd0;
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            start_ff <= csr_pwdata[26:0];
         end else begin
            interval_ff <= csr_pwdata[16:0];
         end
      end
   end

   bsec_front #(
      .MODE_CODES (MODE_CODES),
      .MAX_BINS   (MAX_BINS)
   ) u_front (
      .op            (req_op),
      .seg_id        (req_seg_id),
      .entry_time_ms (req_entry_time_ms),
      .mode_code     (req_mode_code),
      .read_bin      (req_read_bin),
      .cmd           (cmd)
   );

   bsec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   bsec_back #(
      .SEGMENT_SLOTS (SEGMENT_SLOTS),
      .MODE_CODES    (MODE_CODES),
      .MAX_BINS      (MAX_BINS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .clearing         (clearing),
      .interval_seconds (interval_ff),
      .start_time_ms    (start_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_count_value  (rsp_count_value)
   );

   // Error results carry no bin and no count.
   `BSEC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_bin_index == 7'd0 && rsp_count_value == 32'd0, "error result with payload")
   // No request is taken while the count memory is being cleared.
   `BSEC_ASSERT_NOW(a_clr_stall, clock, reset, clearing, !push, "request taken during clear")
   // A pop only happens with something in the queue.
   `BSEC_ASSERT_NOW(a_pop_valid, clock, reset, pop, head.valid, "pop from empty queue")
   // Once clearing ends it never restarts.
   `BSEC_ASSERT_NEXT(a_clr_once, clock, reset, !clearing, !clearing, "clear pass restarted")

endmodule

// ===== rtl/core/bsec_front.sv =====
// Front end: decode op, fold mode code and range-check the read bin.
module bsec_front import bsec_pkg::*; #(
   parameter int MODE_CODES = 8,
   parameter int MAX_BINS   = 96
) (
   input  logic [1:0]  op,
   input  logic [31:0] seg_id,
   input  logic [26:0] entry_time_ms,
   input  logic [2:0]  mode_code,
   input  logic [6:0]  read_bin,
   output cmd_type     cmd
);

   function automatic logic [2:0] fold_mode(input logic [2:0] m_in);
      logic [6:0] m;
      m = {4'b0, m_in};
      for (int k = 0; k < 8; k++) begin
         if (m >= 7'(MODE_CODES)) begin
            m = m - 7'(MODE_CODES);
         end
      end
      return m[2:0];
   endfunction

   always_comb begin
      unique case (op)
         OP_LOAD:  cmd.kind = KIND_LOAD;
         OP_COUNT: cmd.kind = KIND_COUNT;
         OP_READ:  cmd.kind = KIND_READ;
         default:  cmd.kind = KIND_NOP;
      endcase
      cmd.seg_id        = seg_id;
      cmd.entry_time_ms = entry_time_ms;
      cmd.mode          = fold_mode(mode_code);
      cmd.read_bin      = read_bin;
      cmd.read_bin_ok   = (read_bin != 7'd0) && (32'(read_bin) <= 32'(MAX_BINS));
   end

endmodule

// ===== rtl/core/bsec_queue.sv =====
// Two-entry command queue between front end and back end.
module bsec_queue import bsec_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output qout_type head
);

   cmd_type     slot_ff [2];
   logic        rd_ptr_ff, rd_ptr_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/bsec_back.sv =====
// Back end: set search, serial divider, count memory and result register.
module bsec_back import bsec_pkg::*; #(
   parameter int SEGMENT_SLOTS = 64,
   parameter int MODE_CODES    = 8,
   parameter int MAX_BINS      = 96
) (
   input  logic        clock,
   input  logic        reset,
   input  qout_type    head,
   output logic        pop,
   output logic        clearing,
   input  logic [16:0] interval_seconds,
   input  logic [26:0] start_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_bin_index,
   output logic [31:0] rsp_count_value
);

   localparam int SW    = SEGMENT_SLOTS > 1 ? $clog2(SEGMENT_SLOTS) : 1;
   localparam int CW    = $clog2(SEGMENT_SLOTS + 1);
   localparam int CELLS = MAX_BINS * SEGMENT_SLOTS * MODE_CODES;
   localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
   localparam int BW    = $clog2(MAX_BINS + 1);
   localparam int DVW   = 29;
   localparam int DCW   = 5;
   // floor(x / 1000) == (x * SEC_RECIP) >> SEC_SHIFT for every x below 2**29
   localparam logic [29:0] SEC_RECIP = 30'd549755814;
   localparam int          SEC_SHIFT = 39;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RD, S_CMP, S_SEC, S_DIV, S_DIV_END, S_IDX1, S_IDX2,
      S_CRD, S_CUPD, S_RES
   } state_type;

   state_type      state_ff;
   cmd_type        cmd_ff;
   logic [CW-1:0]  fill_ff;
   logic [CW-1:0]  scan_ff;
   logic [SW-1:0]  slot_ff;
   logic [31:0]    id_rd_ff;
   logic [AW-1:0]  clr_ff;
   logic [DVW-1:0] dvd_ff;
   logic [16:0]    rem_ff;
   logic [16:0]    dvs_ff;
   logic [DCW-1:0] step_ff;
   logic           phase_ff;
   logic [BW-1:0]  binm1_ff;
   logic [AW-1:0]  t_ff;
   logic [AW-1:0]  addr_ff;
   logic [31:0]    cnt_rd_ff;
   logic [2:0]     res_status_ff;
   logic [6:0]     res_bin_ff;
   logic [31:0]    res_count_ff;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [6:0]     rsp_bin_ff;
   logic [31:0]    rsp_count_ff;

   logic [31:0]    id_mem [SEGMENT_SLOTS];
   logic [31:0]    cnt_mem [CELLS];

   logic [17:0]    shifted_in;
   logic           sub_ok_in;
   logic [16:0]    width_in;
   logic [31:0]    cnt_inc_in;
   logic           out_free_in;
   logic [58:0]    sec_prod_in;

   always_comb begin
      shifted_in  = {rem_ff, dvd_ff[DVW-1]};
      sub_ok_in   = shifted_in >= {1'b0, dvs_ff};
      width_in    = (interval_seconds == 17'd0) ? 17'd1 : interval_seconds;
      cnt_inc_in  = (cnt_rd_ff == 32'hFFFF_FFFF) ? cnt_rd_ff : cnt_rd_ff + 32'd1;
      out_free_in = !rsp_valid_ff || !rsp_stall;
      sec_prod_in = dvd_ff * SEC_RECIP;
   end

   assign pop             = (state_ff == S_IDLE) && head.valid;
   assign clearing        = (state_ff == S_CLR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bin_index   = rsp_bin_ff;
   assign rsp_count_value = rsp_count_ff;

   // Memories: identifier store and count store.
   always_ff @(posedge clock) begin
      id_rd_ff <= id_mem[scan_ff[SW-1:0]];
      if (state_ff == S_CMP && cmd_ff.kind == KIND_LOAD && scan_ff == fill_ff &&
          fill_ff != CW'(SEGMENT_SLOTS)) begin
         id_mem[fill_ff[SW-1:0]] <= cmd_ff.seg_id;
      end
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[addr_ff];
      if (state_ff == S_CLR) begin
         cnt_mem[clr_ff] <= 32'd0;
      end else if (state_ff == S_CUPD && cmd_ff.kind == KIND_COUNT) begin
         cnt_mem[addr_ff] <= cnt_inc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_RES && out_free_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (head.valid) begin
                  cmd_ff  <= head.cmd;
                  scan_ff <= '0;
                  if (head.cmd.kind == KIND_NOP) begin
                     res_status_ff <= ST_OK;
                     res_bin_ff    <= 7'd0;
                     res_count_ff  <= 32'd0;
                     state_ff      <= S_RES;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               res_bin_ff   <= 7'd0;
               res_count_ff <= 32'd0;
               if (scan_ff != fill_ff && id_rd_ff == cmd_ff.seg_id) begin
                  // Hit: slot found.
                  slot_ff <= scan_ff[SW-1:0];
                  unique case (cmd_ff.kind)
                     KIND_COUNT: begin
                        dvd_ff   <= DVW'(cmd_ff.entry_time_ms) + DVW'(start_time_ms)
                                    + DVW'(MS_PER_SECOND - 1);
                        phase_ff <= 1'b0;
                        state_ff <= S_SEC;
                     end
                     KIND_READ: begin
                        if (cmd_ff.read_bin_ok) begin
                           binm1_ff <= BW'(cmd_ff.read_bin - 7'd1);
                           state_ff <= S_IDX1;
                        end else begin
                           res_status_ff <= ST_BIN_OOR;
                           state_ff      <= S_RES;
                        end
                     end
                     default: begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_RES;
                     end
                  endcase
               end else if (scan_ff == fill_ff || scan_ff + CW'(1) == fill_ff) begin
                  // Miss: whole set scanned.
                  if (cmd_ff.kind == KIND_LOAD) begin
                     if (fill_ff == CW'(SEGMENT_SLOTS)) begin
                        res_status_ff <= ST_SET_FULL;
                        state_ff      <= S_RES;
                     end else if (scan_ff == fill_ff) begin
                        res_status_ff <= ST_OK;
                        fill_ff       <= fill_ff + CW'(1);
                        state_ff      <= S_RES;
                     end else begin
                        scan_ff  <= fill_ff;
                        state_ff <= S_CMP;
                     end
                  end else begin
                     res_status_ff <= ST_NO_SEG;
                     state_ff      <= S_RES;
                  end
               end else begin
                  scan_ff  <= scan_ff + CW'(1);
                  state_ff <= S_RD;
               end
            end
            S_SEC: begin
               // Whole seconds by reciprocal multiplication.
               dvd_ff   <= DVW'(sec_prod_in[58:SEC_SHIFT]);
               state_ff <= S_DIV_END;
            end
            S_DIV: begin
               dvd_ff  <= {dvd_ff[DVW-2:0], sub_ok_in};
               rem_ff  <= sub_ok_in ? 17'(shifted_in - {1'b0, dvs_ff}) : shifted_in[16:0];
               step_ff <= step_ff + DCW'(1);
               if (step_ff == DCW'(DVW - 1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               if (!phase_ff) begin
                  if (dvd_ff >= DVW'(SECONDS_PER_DAY)) begin
                     res_status_ff <= ST_TIME_DAY;
                     state_ff      <= S_RES;
                  end else begin
                     dvs_ff   <= width_in;
                     rem_ff   <= '0;
                     step_ff  <= '0;
                     phase_ff <= 1'b1;
                     state_ff <= S_DIV;
                  end
               end else if (dvd_ff >= DVW'(MAX_BINS)) begin
                  res_status_ff <= ST_BIN_OOR;
                  state_ff      <= S_RES;
               end else begin
                  binm1_ff <= BW'(dvd_ff);
                  state_ff <= S_IDX1;
               end
            end
            S_IDX1: begin
               t_ff     <= AW'(AW'(binm1_ff) * AW'(SEGMENT_SLOTS)) + AW'(slot_ff);
               state_ff <= S_IDX2;
            end
            S_IDX2: begin
               addr_ff  <= AW'(t_ff * AW'(MODE_CODES)) + AW'(cmd_ff.mode);
               state_ff <= S_CRD;
            end
            S_CRD: begin
               state_ff <= S_CUPD;
            end
            S_CUPD: begin
               res_status_ff <= ST_OK;
               res_bin_ff    <= 7'(binm1_ff + BW'(1));
               res_count_ff  <= (cmd_ff.kind == KIND_COUNT) ? cnt_inc_in : cnt_rd_ff;
               state_ff      <= S_RES;
            end
            S_RES: begin
               if (out_free_in) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_bin_ff    <= res_bin_ff;
                  rsp_count_ff  <= res_count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sim/bsec_checker.sv =====
// Checker: watches the request, result and register-write channels, predicts results and compares.
module bsec_checker import bsec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_seg_id,
   input  logic [26:0] req_entry_time_ms,
   input  logic [2:0]  req_mode_code,
   input  logic [6:0]  req_read_bin,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [6:0]  rsp_bin_index,
   input  logic [31:0] rsp_count_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 64;
   localparam int MODES = 8;
   localparam int BINS  = 96;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  bin;
      logic [31:0] count;
   } answer_type;

   logic [16:0] bin_width;
   logic [26:0] day_offset_ms;
   logic [31:0] seg_ids [SLOTS];
   logic        seg_used [SLOTS];
   logic [31:0] tally [BINS*SLOTS*MODES];
   answer_type  answers_due [$];

   function automatic int find_seg(input logic [31:0] id);
      for (int s = 0; s < SLOTS; s++)
         if (seg_used[s] && seg_ids[s] == id) return s;
      return -1;
   endfunction

   function automatic answer_type predict_answer(input logic [1:0] op,
                                                 input logic [31:0] id,
                                                 input logic [26:0] entry,
                                                 input logic [2:0] mode,
                                                 input logic [6:0] rbin);
      answer_type a;
      int slot;
      longint secs;
      int w, b, idx;
      a = '0;
      case (op)
         OP_LOAD: begin
            if (find_seg(id) < 0) begin
               a.status = ST_SET_FULL;
               for (int s = 0; s < SLOTS; s++)
                  if (!seg_used[s]) begin
                     seg_used[s] = 1'b1;
                     seg_ids[s] = id;
                     a.status = ST_OK;
                     break;
                  end
            end
         end
         OP_COUNT: begin
            slot = find_seg(id);
            secs = (longint'(entry) + longint'(day_offset_ms) + MS_PER_SECOND - 1) / MS_PER_SECOND;
            w = (bin_width == 0) ? 1 : int'(bin_width);
            if (slot < 0) a.status = ST_NO_SEG;
            else if (secs >= SECONDS_PER_DAY) a.status = ST_TIME_DAY;
            else begin
               b = int'(secs) / w + 1;
               if (b > BINS) a.status = ST_BIN_OOR;
               else begin
                  idx = ((b - 1) * SLOTS + slot) * MODES + mode % MODES;
                  if (tally[idx] != 32'hFFFF_FFFF) tally[idx]++;
                  a.bin = b[6:0];
                  a.count = tally[idx];
               end
            end
         end
         OP_READ: begin
            slot = find_seg(id);
            if (slot < 0) a.status = ST_NO_SEG;
            else if (rbin == 0 || rbin > BINS) a.status = ST_BIN_OOR;
            else begin
               a.bin = rbin;
               a.count = tally[((int'(rbin) - 1) * SLOTS + slot) * MODES + mode % MODES];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         bin_width <= 17'd900;
         day_offset_ms <= '0;
         for (int s = 0; s < SLOTS; s++) seg_used[s] = 1'b0;
         for (int i = 0; i < BINS*SLOTS*MODES; i++) tally[i] = '0;
         answers_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == 3'd0) bin_width <= csr_pwdata[16:0];
            else if (csr_paddr == 3'd4) day_offset_ms <= csr_pwdata[26:0];
         end
         if (req_valid && !req_stall)
            answers_due = {answers_due,
                           predict_answer(req_op, req_seg_id, req_entry_time_ms,
                                          req_mode_code, req_read_bin)};
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_bin_index, rsp_count_value};
            if (answers_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want !== got) begin
                  if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = answers_due.size();
endmodule

// ===== sim/tb.sv =====
// Testbench top: drives requests, result stalls and register writes, and gives the verdict.
module tb import bsec_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [31:0] req_seg_id = '0;
   logic [26:0] req_entry_time_ms = '0;
   logic [2:0]  req_mode_code = '0;
   logic [6:0]  req_read_bin = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_bin_index;
   logic [31:0] rsp_count_value;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   bit          calm = 1'b0;  // no idling on either side in the last stretch

   localparam logic [2:0] ADDR_INTERVAL = 3'd0;
   localparam logic [2:0] ADDR_START    = 3'd4;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // Segment IDs in the monitored set, so that most counts and reads hit.
   logic [31:0] known_segs [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   binned_segment_event_counter_top dut (.*);

   bsec_checker checker_i (.*);

   // Result side: stall in random bursts until the calm stretch.
   always @(posedge clock) begin
      int burst;
      if (!calm && $urandom_range(0, 9) == 0) begin
         burst = $urandom_range(1, 17);
         rsp_stall <= 1'b1;
         repeat (burst) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Hold one request until accepted; outside the calm stretch, drop valid now and then for a random gap.
   task automatic send_request(input logic [1:0] op, input logic [31:0] id,
                               input logic [26:0] entry, input logic [2:0] mode,
                               input logic [6:0] rbin);
      req_valid <= 1'b1;
      req_op <= op;
      req_seg_id <= id;
      req_entry_time_ms <= entry;
      req_mode_code <= mode;
      req_read_bin <= rbin;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Setup then access cycle; the register takes the value at the access edge.
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] pick_seg();
      if (known_segs.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
      return known_segs[$urandom_range(0, known_segs.size() - 1)];
   endfunction

   task automatic random_phase(input int n);
      logic [31:0] id;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: begin
               id = $urandom();
               if (known_segs.size() < 64) known_segs = {known_segs, id};
               send_request(OP_LOAD, id, '0, '0, '0);
            end
            1: send_request(OP_LOAD, pick_seg(), 27'($urandom()), 3'($urandom()),
                            7'($urandom()));
            2: send_request(OP_UNUSED, $urandom(), 27'($urandom()), 3'($urandom()),
                            7'($urandom()));
            3, 4, 5, 6, 7:
               send_request(OP_READ, pick_seg(), 27'($urandom()), 3'($urandom()),
                            ($urandom_range(0, 9) == 0) ? 7'($urandom())
                                                        : 7'($urandom_range(1, 96)));
            default:
               send_request(OP_COUNT, pick_seg(),
                            ($urandom_range(0, 9) == 0) ? 27'($urandom())
                                                        : 27'($urandom_range(0, 86399999)),
                            3'($urandom()), 7'($urandom()));
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: loads, duplicate, unknown op, counts and reads at the edges.
      known_segs = {known_segs, 32'h0};
      known_segs = {known_segs, 32'hFFFF_FFFF};
      send_request(OP_LOAD, 32'h0, '0, '0, '0);
      send_request(OP_LOAD, 32'hFFFF_FFFF, 27'h7FF_FFFF, 3'd7, 7'h7F);
      send_request(OP_LOAD, 32'h0, '0, '0, '0);
      send_request(OP_UNUSED, 32'h0, 27'h7FF_FFFF, 3'd7, 7'h7F);
      send_request(OP_COUNT, 32'h0, '0, '0, '0);
      send_request(OP_COUNT, 32'h0, 27'd1, 3'd7, '0);
      send_request(OP_COUNT, 32'hFFFF_FFFF, 27'd86399000, 3'd3, '0);
      send_request(OP_COUNT, 32'hFFFF_FFFF, 27'd86399001, 3'd3, '0);
      send_request(OP_COUNT, 32'hFFFF_FFFF, 27'h7FF_FFFF, 3'd3, '0);
      send_request(OP_COUNT, 32'h1234_5678, 27'd5, 3'd0, '0);
      send_request(OP_READ, 32'h0, '0, 3'd0, 7'd1);
      send_request(OP_READ, 32'h0, '0, 3'd7, 7'd1);
      send_request(OP_READ, 32'hFFFF_FFFF, '0, 3'd3, 7'd96);
      send_request(OP_READ, 32'h0, '0, 3'd0, 7'd0);
      send_request(OP_READ, 32'h0, '0, 3'd0, 7'd97);
      send_request(OP_READ, 32'h0, '0, 3'd0, 7'h7F);
      send_request(OP_READ, 32'h5555_AAAA, '0, 3'd0, 7'd1);
      wait_drained();

      // Bins of one second: most times overflow the store.
      write_reg(ADDR_INTERVAL, 32'd1);
      write_reg(ADDR_START, 32'd0);
      send_request(OP_COUNT, 32'h0, 27'd94999, 3'd1, '0);
      send_request(OP_COUNT, 32'h0, 27'd95001, 3'd1, '0);
      random_phase(300);
      wait_drained();

      // Zero interval behaves as one; start near the end of the day.
      write_reg(ADDR_INTERVAL, 32'd0);
      write_reg(ADDR_START, 32'd86399999);
      send_request(OP_COUNT, 32'h0, '0, 3'd2, '0);
      send_request(OP_COUNT, 32'hFFFF_FFFF, '0, 3'd2, '0);
      random_phase(200);
      wait_drained();

      // Fill the set to see the full status.
      write_reg(ADDR_INTERVAL, 32'd86400);
      write_reg(ADDR_START, 32'd43200000);
      while (known_segs.size() < 64) begin
         known_segs = {known_segs, 32'($urandom())};
         send_request(OP_LOAD, known_segs[$], '0, '0, '0);
      end
      send_request(OP_LOAD, 32'hDEAD_0001, '0, '0, '0);
      send_request(OP_LOAD, 32'hDEAD_0002, '0, '0, '0);
      random_phase(300);
      wait_drained();

      write_reg(ADDR_INTERVAL, 32'h1FFFF);
      write_reg(ADDR_START, 32'h7FF_FFFF);
      random_phase(200);
      wait_drained();

      write_reg(ADDR_INTERVAL, 32'd900);
      write_reg(ADDR_START, 32'd1500);
      random_phase(500);
      wait_drained();
      write_reg(ADDR_START, 32'd0);
      write_reg(ADDR_INTERVAL, 32'd901);
      calm = 1'b1;
      random_phase(300);
      wait_drained();

      if (fail_count == 0) $display("binned_segment_event_counter_top test passed");
      else $display("binned_segment_event_counter_top test failed");
      $finish;
   end

   initial begin
      #60ms;
      $display("binned_segment_event_counter_top test failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bsec_pkg.sv
rtl/core/bsec_front.sv
rtl/core/bsec_queue.sv
rtl/core/bsec_back.sv
rtl/core/binned_segment_event_counter_top.sv
sim/bsec_checker.sv
sim/tb.sv
